// ===== sv/first_fit_block_allocator_unit_macros.svh =====
// assertion macros for the allocator checker
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define FFBA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define FFBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ffba_pkg.sv =====
package ffba_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam int IDX_BITS   = $clog2(MAX_BLOCKS);
    localparam int CNT_BITS   = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_BITS  = 16;
    localparam int SIZE_BITS  = ADDR_BITS + 1;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_FREE    = 2'd1;
    localparam logic [1:0] MODE_REALLOC = 2'd2;
    localparam logic [1:0] MODE_NOP     = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [SIZE_BITS-1:0] REGION_MAX = SIZE_BITS'(1) << ADDR_BITS;

    // one table entry
    typedef struct packed {
        logic [ADDR_BITS-1:0] offset;
        logic [SIZE_BITS-1:0] size;
        logic                 used;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

endpackage

// ===== sv/ffba_table_ram.sv =====
// entry table: one write port, one registered read port
module ffba_table_ram (
    input  logic                               aclk,
    input  logic                               wr_en,
    input  logic [ffba_pkg::IDX_BITS-1:0]      wr_addr,
    input  ffba_pkg::entry_t                   wr_data,
    input  logic [ffba_pkg::IDX_BITS-1:0]      rd_addr,
    output ffba_pkg::entry_t                   rd_data
);

    ffba_pkg::entry_t mem [ffba_pkg::MAX_BLOCKS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/first_fit_block_allocator_unit.sv =====
// first-fit block allocator over an address-ordered table in one sync ram
// the table is walked one entry at a time, each entry read and then checked; an alloc
//   walks the table from accept to result, while an early failure goes straight to the result
// a moving realloc walks the table three times: find, fit, then release of the old block
// throughput: one request at a time; the result waits in an output register
// reset (synchronous, aresetn low): table empty, total_size and free count 65536
module first_fit_block_allocator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: mode[1:0], block_address[17:2], request_size[34:18], zero pad
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    // tdata: result_address[15:0], status[17:16], free_after[34:18], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AB = ffba_pkg::ADDR_BITS;
    localparam int SB = ffba_pkg::SIZE_BITS;
    localparam int IB = ffba_pkg::IDX_BITS;
    localparam int CB = ffba_pkg::CNT_BITS;

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_RD      = 15'b000000000000010,
        S_CHK     = 15'b000000000000100,
        S_FIT     = 15'b000000000001000,
        S_TAIL    = 15'b000000000010000,
        S_FOUND   = 15'b000000000100000,
        S_PEEK    = 15'b000000001000000,
        S_PEEKCHK = 15'b000000010000000,
        S_SHRD    = 15'b000000100000000,
        S_SHWR    = 15'b000001000000000,
        S_INS     = 15'b000010000000000,
        S_WRN     = 15'b000100000000000,
        S_WRP     = 15'b001000000000000,
        S_REL     = 15'b010000000000000,
        S_OUT     = 15'b100000000000000
    } state_t;

    // what the table walk is looking for
    typedef enum logic [2:0] {
        W_FIT  = 3'b001,
        W_FIND = 3'b010,
        W_OLD  = 3'b100
    } walk_t;

    state_t state_reg;
    walk_t  walk_reg;

    logic [1:0]       mode_reg;
    logic [AB-1:0]    baddr_reg;
    logic [SB-1:0]    req_reg;
    logic [SB-1:0]    total_reg;
    logic [SB-1:0]    free_reg;
    logic [CB-1:0]    count_reg;
    logic [CB-1:0]    idx_reg;
    logic [SB-1:0]    end_reg;
    ffba_pkg::entry_t cur_reg;
    logic [AB-1:0]    res_reg;
    logic [1:0]       st_reg;
    logic             move_reg;
    ffba_pkg::entry_t ins_reg;
    logic [CB-1:0]    ins_pos_reg;
    logic [CB-1:0]    sh_reg;
    ffba_pkg::entry_t prim_reg;
    logic [IB-1:0]    prim_idx_reg;
    logic             out_valid_reg;
    logic [AB-1:0]    out_res_reg;
    logic [1:0]       out_st_reg;
    logic [SB-1:0]    out_free_reg;

    logic             wr_en;
    logic [IB-1:0]    wr_addr, rd_addr;
    ffba_pkg::entry_t wr_data, rd_data;

    ffba_table_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(total_reg) : 32'd0;

    assign s_tready = (state_reg == S_IDLE) && !cfg_wr;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_free_reg, out_st_reg, out_res_reg};

    // tail room after the last block
    logic [SB-1:0] tail;
    assign tail = (end_reg >= total_reg) ? '0 : total_reg - end_reg;

    // growth of a realloc
    logic [SB-1:0] diff;
    assign diff = req_reg - cur_reg.size;

    logic full;
    assign full = (count_reg == CB'(ffba_pkg::MAX_BLOCKS));

    // found entry marked unused
    ffba_pkg::entry_t rel_data;
    assign rel_data = '{offset: cur_reg.offset, size: cur_reg.size, used: 1'b0};

    // result register loads when free or being drained
    logic out_load;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    // ram port control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ins_pos_reg[IB-1:0];
        wr_data = ins_reg;
        rd_addr = idx_reg[IB-1:0];
        unique case (state_reg)
            S_PEEK: begin
                rd_addr = idx_reg[IB-1:0] + IB'(1);
            end
            S_SHRD: begin
                if (sh_reg != ins_pos_reg) begin
                    rd_addr = sh_reg[IB-1:0] - IB'(1);
                end
            end
            S_SHWR: begin
                wr_en   = 1'b1;
                wr_addr = sh_reg[IB-1:0];
                wr_data = rd_data;
            end
            S_INS, S_WRN: begin
                wr_en = 1'b1;
            end
            S_WRP: begin
                wr_en   = 1'b1;
                wr_addr = prim_idx_reg;
                wr_data = prim_reg;
            end
            S_REL: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[IB-1:0];
                wr_data = rel_data;
            end
            default: ;
        endcase
    end

    logic [SB-1:0] cfg_val;
    logic [SB-1:0] sat;
    assign cfg_val = pwdata[SB-1:0];
    assign sat = (cfg_val > ffba_pkg::REGION_MAX) ? ffba_pkg::REGION_MAX : cfg_val;

    // main sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            walk_reg  <= W_FIT;
            count_reg <= '0;
            total_reg <= ffba_pkg::REGION_MAX;
            free_reg  <= ffba_pkg::REGION_MAX;
            move_reg  <= 1'b0;
        end else if (cfg_wr && paddr[2] == 1'b0) begin
            total_reg <= sat;
            free_reg  <= sat;
            count_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        mode_reg  <= s_tdata[1:0];
                        baddr_reg <= s_tdata[17:2];
                        req_reg   <= s_tdata[34:18];
                        idx_reg   <= '0;
                        end_reg   <= '0;
                        res_reg   <= '0;
                        st_reg    <= ffba_pkg::ST_OK;
                        move_reg  <= 1'b0;
                        if (s_tdata[1:0] == ffba_pkg::MODE_ALLOC) begin
                            walk_reg <= W_FIT;
                            if (s_tdata[34:18] == '0 || s_tdata[34:18] > free_reg) begin
                                st_reg    <= ffba_pkg::ST_NOSPACE;
                                state_reg <= S_OUT;
                            end else begin
                                state_reg <= (count_reg == '0) ? S_TAIL : S_RD;
                            end
                        end else if (s_tdata[1:0] == ffba_pkg::MODE_FREE ||
                                     s_tdata[1:0] == ffba_pkg::MODE_REALLOC) begin
                            walk_reg <= W_FIND;
                            if (count_reg == '0) begin
                                st_reg    <= ffba_pkg::ST_NOTFOUND;
                                state_reg <= S_OUT;
                            end else begin
                                state_reg <= S_RD;
                            end
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_RD: state_reg <= S_CHK;
                // check one entry, then step or finish the walk
                S_CHK: begin
                    cur_reg <= rd_data;
                    end_reg <= SB'(rd_data.offset) + rd_data.size;
                    if (walk_reg == W_FIT && !rd_data.used && rd_data.size >= req_reg) begin
                        state_reg <= S_FIT;
                    end else if (walk_reg == W_FIND && rd_data.offset == baddr_reg) begin
                        state_reg <= S_FOUND;
                    end else if (walk_reg == W_OLD && rd_data.offset == baddr_reg) begin
                        state_reg <= S_REL;
                    end else if (idx_reg + CB'(1) >= count_reg) begin
                        if (walk_reg == W_FIT) begin
                            state_reg <= S_TAIL;
                        end else if (walk_reg == W_FIND) begin
                            st_reg    <= ffba_pkg::ST_NOTFOUND;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end else begin
                        idx_reg   <= idx_reg + CB'(1);
                        state_reg <= S_RD;
                    end
                end
                // first fit found: take it, split off any excess, or fail as full if no slot is left for the split
                S_FIT: begin
                    if (cur_reg.size > req_reg && full) begin
                        st_reg    <= ffba_pkg::ST_FULL;
                        state_reg <= S_OUT;
                    end else begin
                        free_reg     <= free_reg - req_reg;
                        res_reg      <= cur_reg.offset;
                        prim_reg     <= '{offset: cur_reg.offset, size: req_reg, used: 1'b1};
                        prim_idx_reg <= idx_reg[IB-1:0];
                        ins_reg      <= '{offset: cur_reg.offset + req_reg[AB-1:0],
                                          size: cur_reg.size - req_reg, used: 1'b0};
                        ins_pos_reg  <= idx_reg + CB'(1);
                        sh_reg       <= count_reg;
                        state_reg    <= (cur_reg.size > req_reg) ? S_SHRD : S_WRP;
                    end
                end
                // append after the last block
                S_TAIL: begin
                    if (tail < req_reg) begin
                        st_reg    <= ffba_pkg::ST_NOSPACE;
                        state_reg <= S_OUT;
                    end else if (full) begin
                        st_reg    <= ffba_pkg::ST_FULL;
                        state_reg <= S_OUT;
                    end else begin
                        ins_reg      <= '{offset: end_reg[AB-1:0], size: req_reg, used: 1'b1};
                        prim_reg     <= '{offset: end_reg[AB-1:0], size: req_reg, used: 1'b1};
                        prim_idx_reg <= count_reg[IB-1:0];
                        ins_pos_reg  <= count_reg;
                        sh_reg       <= count_reg;
                        free_reg     <= free_reg - req_reg;
                        res_reg      <= end_reg[AB-1:0];
                        state_reg    <= S_SHRD;
                    end
                end
                // free or realloc of a located block
                S_FOUND: begin
                    if (mode_reg == ffba_pkg::MODE_FREE) begin
                        res_reg   <= baddr_reg;
                        state_reg <= cur_reg.used ? S_REL : S_OUT;
                    end else if (!cur_reg.used) begin
                        st_reg    <= ffba_pkg::ST_NOTFOUND;
                        state_reg <= S_OUT;
                    end else if (req_reg == '0 ||
                                 (req_reg > cur_reg.size && free_reg < diff)) begin
                        st_reg    <= ffba_pkg::ST_NOSPACE;
                        state_reg <= S_OUT;
                    end else if (req_reg == cur_reg.size) begin
                        res_reg   <= cur_reg.offset;
                        state_reg <= S_OUT;
                    end else if (req_reg < cur_reg.size) begin
                        if (full) begin
                            st_reg    <= ffba_pkg::ST_FULL;
                            state_reg <= S_OUT;
                        end else begin
                            free_reg     <= free_reg + (cur_reg.size - req_reg);
                            res_reg      <= cur_reg.offset;
                            prim_reg     <= '{offset: cur_reg.offset, size: req_reg,
                                              used: 1'b1};
                            prim_idx_reg <= idx_reg[IB-1:0];
                            ins_reg      <= '{offset: cur_reg.offset + req_reg[AB-1:0],
                                              size: cur_reg.size - req_reg, used: 1'b0};
                            ins_pos_reg  <= idx_reg + CB'(1);
                            sh_reg       <= count_reg;
                            state_reg    <= S_SHRD;
                        end
                    end else if (idx_reg + CB'(1) == count_reg) begin
                        if (tail >= diff) begin
                            free_reg     <= free_reg - diff;
                            res_reg      <= cur_reg.offset;
                            prim_reg     <= '{offset: cur_reg.offset, size: req_reg,
                                              used: 1'b1};
                            prim_idx_reg <= idx_reg[IB-1:0];
                            state_reg    <= S_WRP;
                        end else if (req_reg > free_reg) begin
                            st_reg    <= ffba_pkg::ST_NOSPACE;
                            state_reg <= S_OUT;
                        end else begin
                            walk_reg  <= W_FIT;
                            idx_reg   <= '0;
                            move_reg  <= 1'b1;
                            state_reg <= S_RD;
                        end
                    end else begin
                        state_reg <= S_PEEK;
                    end
                end
                S_PEEK: state_reg <= S_PEEKCHK;
                // grow into the next block when it is unused and big enough
                S_PEEKCHK: begin
                    if (!rd_data.used && rd_data.size > diff) begin
                        free_reg     <= free_reg - diff;
                        res_reg      <= cur_reg.offset;
                        prim_reg     <= '{offset: cur_reg.offset, size: req_reg, used: 1'b1};
                        prim_idx_reg <= idx_reg[IB-1:0];
                        ins_reg      <= '{offset: rd_data.offset + diff[AB-1:0],
                                          size: rd_data.size - diff, used: 1'b0};
                        ins_pos_reg  <= idx_reg + CB'(1);
                        state_reg    <= S_WRN;
                    end else if (req_reg > free_reg) begin
                        st_reg    <= ffba_pkg::ST_NOSPACE;
                        state_reg <= S_OUT;
                    end else begin
                        walk_reg  <= W_FIT;
                        idx_reg   <= '0;
                        move_reg  <= 1'b1;
                        state_reg <= S_RD;
                    end
                end
                // shift entries up by one to open the insert slot
                S_SHRD: begin
                    state_reg <= (sh_reg == ins_pos_reg) ? S_INS : S_SHWR;
                end
                S_SHWR: begin
                    sh_reg    <= sh_reg - CB'(1);
                    state_reg <= S_SHRD;
                end
                S_INS: begin
                    count_reg <= count_reg + CB'(1);
                    state_reg <= S_WRP;
                end
                S_WRN: state_reg <= S_WRP;
                // primary entry written; a move then releases the old block
                S_WRP: begin
                    if (move_reg) begin
                        move_reg  <= 1'b0;
                        walk_reg  <= W_OLD;
                        idx_reg   <= '0;
                        state_reg <= S_RD;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_REL: begin
                    free_reg  <= free_reg + cur_reg.size;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
            out_res_reg   <= (st_reg == ffba_pkg::ST_OK) ? res_reg : '0;
            out_st_reg    <= st_reg;
            out_free_reg  <= free_reg;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== sv/ffba_checker.sv =====
`include "first_fit_block_allocator_unit_macros.svh"

// port-level checks on the allocator
module ffba_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        pready
);

    `FFBA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `FFBA_ASSERT_NEXT(a_one_at_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second item taken while busy")
    `FFBA_ASSERT_IMPL(a_fail_zero, aclk, aresetn, m_tvalid && m_tdata[17:16] != ffba_pkg::ST_OK, m_tdata[15:0] == '0, "failed result with nonzero address")
    `FFBA_ASSERT_IMPL(a_free_bound, aclk, aresetn, m_tvalid, m_tdata[34:18] <= ffba_pkg::REGION_MAX, "free count beyond region")
    `FFBA_ASSERT_IMPL(a_pready, aclk, aresetn, 1'b1, pready, "pready low")

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
